// ===== hw/rtl/ensc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ensc_pkg;

	typedef struct packed {
		logic [23:0] raw_temp;
		logic [23:0] raw_press;
		logic [15:0] raw_humid;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] temp_centideg;
		logic [16:0]        humid_q22_10;
		logic [31:0]        press_q24_8;
		logic [1:0]         press_status;
	} result_t;

	// front to back: finished temperature and humidity plus the pressure division operands
	typedef struct packed {
		logic signed [31:0] tc;
		logic [16:0]        hum;
		logic [1:0]         st;
		logic signed [63:0] num;
		logic signed [63:0] den;
	} mid_t;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
		logic [7:0]  h1;
		logic [15:0] h2;
		logic [7:0]  h3;
		logic [15:0] h4;
		logic [15:0] h5;
		logic [7:0]  h6;
	} coef_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DISABLED = 2'd1;
	localparam logic [1:0] ST_DIV_ZERO = 2'd2;

	localparam logic [2:0] REG_TEMP    = 3'd0;
	localparam logic [2:0] REG_PRESS_A = 3'd1;
	localparam logic [2:0] REG_PRESS_B = 3'd2;
	localparam logic [2:0] REG_PRESS_C = 3'd3;
	localparam logic [2:0] REG_HUMID_A = 3'd4;
	localparam logic [2:0] REG_HUMID_B = 3'd5;

	localparam logic [23:0]        RAW_DISABLED = 24'h800000;
	localparam logic signed [31:0] HUM_ACC_MAX  = 32'sd419430400;
	localparam logic [16:0]        HUM_MAX      = 17'd102400;

	function automatic logic signed [31:0] sx16_32(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic signed [31:0] sx8_32(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

	function automatic logic signed [63:0] sx16_64(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	// signed divide by 2**k rounding toward zero
	function automatic logic signed [63:0] sdiv_p2(input logic signed [63:0] x,
		input int unsigned k);
		logic signed [63:0] bias;
		bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
		return (x + bias) >>> k;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ensc_mul64.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ensc_mul64 (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);

	logic [63:0] ll_s1;
	logic [31:0] lh_s1;
	logic [31:0] hl_s1;

	// low 64 bits of the product from three 32x32 partial products
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= 64'(a[31:0]) * 64'(b[31:0]);
			lh_s1 <= a[31:0] * b[63:32];
			hl_s1 <= a[63:32] * b[31:0];
			p     <= ll_s1 + {lh_s1 + hl_s1, 32'd0};
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/ensc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ensc_queue #(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  ensc_pkg::mid_t   wdata,
	input  logic             rd_en,
	output ensc_pkg::mid_t   rdata,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ensc_pkg::mid_t   mem_q [0:DEPTH-1];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_rd;

	assign empty = (cnt_q == '0);
	assign do_rd = rd_en & ~empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			unique case ({wr_en, do_rd})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/ensc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ensc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  ensc_pkg::coef_t   coef,
	input  logic              in_valid,
	input  ensc_pkg::sample_t sample,
	output logic              out_valid,
	output ensc_pkg::mid_t    out_item
);

	logic [12:1] vld_q;

	logic signed [31:0] t2_w, t3_w, h1_w, h2_w, h3_w, h4_w, h5_w, h6_w;
	logic signed [63:0] p1_w, p2_w, p3_w, p4_w, p5_w, p6_w;

	logic [19:0] adt_s1, adp_s1, adp_s2, adp_s3, adp_s4, adp_s5, adp_s6, adp_s7, adp_s8;
	logic [19:0] adp_s9;
	logic [15:0] adh_s1, adh_s2, adh_s3, adh_s4, adh_s5, adh_s6;
	logic dis_s1, dis_s2, dis_s3, dis_s4, dis_s5, dis_s6, dis_s7, dis_s8, dis_s9, dis_s10;
	logic dis_s11, dis_s12;
	logic signed [31:0] tc_s5, tc_s6, tc_s7, tc_s8, tc_s9, tc_s10, tc_s11, tc_s12;

	logic signed [31:0] ta_c, d_c, lpre_c, hfin_c, hclamp_c;
	logic signed [31:0] ma_s2, dd_s2, a_s3, e_s3, fine_s4, x_s5;
	logic signed [31:0] m1_s6, m2_s6, m3_s6, left_s7, inner_s7, left_s8, rmul_s8;
	logic signed [31:0] hv_s9, hv_s10, sqq_s10, hv_s11, m_s11;
	logic [16:0]        hum_s12;

	logic signed [63:0] f_s5, ff_s7, fp5_s7, fp2_s7, u2_s8, fp2sh_s8, u2_s9, fp2sh_s9;
	logic signed [63:0] u1_s9, ffp3_s9, u_s10, w0_s10, pn_s10, diff_s11, n_s12, w1_s12;
	logic signed [63:0] wsum_c, den_c;

	assign t2_w = ensc_pkg::sx16_32(coef.t2);
	assign t3_w = ensc_pkg::sx16_32(coef.t3);
	assign h1_w = {24'd0, coef.h1};
	assign h2_w = ensc_pkg::sx16_32(coef.h2);
	assign h3_w = {24'd0, coef.h3};
	assign h4_w = ensc_pkg::sx16_32(coef.h4);
	assign h5_w = ensc_pkg::sx16_32(coef.h5);
	assign h6_w = ensc_pkg::sx8_32(coef.h6);
	assign p1_w = {48'd0, coef.p1};
	assign p2_w = ensc_pkg::sx16_64(coef.p2);
	assign p3_w = ensc_pkg::sx16_64(coef.p3);
	assign p4_w = ensc_pkg::sx16_64(coef.p4);
	assign p5_w = ensc_pkg::sx16_64(coef.p5);
	assign p6_w = ensc_pkg::sx16_64(coef.p6);

	always_comb begin
		ta_c   = {15'd0, adt_s1[19:3]} - {15'd0, coef.t1, 1'b0};
		d_c    = {16'd0, adt_s1[19:4]} - {16'd0, coef.t1};
		lpre_c = $signed({2'd0, adh_s6, 14'd0}) - (h4_w <<< 20) - m1_s6 + 32'sd16384;
		hfin_c = hv_s11 - (m_s11 >>> 4);
		if (hfin_c[31]) begin
			hclamp_c = '0;
		end else if (hfin_c > ensc_pkg::HUM_ACC_MAX) begin
			hclamp_c = ensc_pkg::HUM_ACC_MAX;
		end else begin
			hclamp_c = hfin_c;
		end
		wsum_c = 64'sd140737488355328 + w0_s10;
		den_c  = ensc_pkg::sdiv_p2(w1_s12, 33);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[11:1], in_valid};
		end
	end

	// temperature and humidity, 32-bit wrapping, plus the 64-bit pressure sums around the multipliers
	always_ff @(posedge clk) begin
		adt_s1 <= sample.raw_temp[23:4];
		adp_s1 <= sample.raw_press[23:4];
		adh_s1 <= sample.raw_humid;
		dis_s1 <= (sample.raw_press == ensc_pkg::RAW_DISABLED);

		ma_s2  <= ta_c * t2_w;
		dd_s2  <= d_c * d_c;
		adp_s2 <= adp_s1;
		adh_s2 <= adh_s1;
		dis_s2 <= dis_s1;

		a_s3   <= ma_s2 >>> 11;
		e_s3   <= (dd_s2 >>> 12) * t3_w;
		adp_s3 <= adp_s2;
		adh_s3 <= adh_s2;
		dis_s3 <= dis_s2;

		fine_s4 <= a_s3 + (e_s3 >>> 14);
		adp_s4  <= adp_s3;
		adh_s4  <= adh_s3;
		dis_s4  <= dis_s3;

		tc_s5  <= ((fine_s4 <<< 2) + fine_s4 + 32'sd128) >>> 8;
		x_s5   <= fine_s4 - 32'sd76800;
		f_s5   <= {{32{fine_s4[31]}}, fine_s4} - 64'sd128000;
		adp_s5 <= adp_s4;
		adh_s5 <= adh_s4;
		dis_s5 <= dis_s4;

		m1_s6  <= h5_w * x_s5;
		m2_s6  <= x_s5 * h6_w;
		m3_s6  <= x_s5 * h3_w;
		adh_s6 <= adh_s5;
		adp_s6 <= adp_s5;
		tc_s6  <= tc_s5;
		dis_s6 <= dis_s5;

		left_s7  <= lpre_c >>> 15;
		inner_s7 <= (m2_s6 >>> 10) * ((m3_s6 >>> 11) + 32'sd32768);
		adp_s7   <= adp_s6;
		tc_s7    <= tc_s6;
		dis_s7   <= dis_s6;

		rmul_s8  <= ((inner_s7 >>> 10) + 32'sd2097152) * h2_w;
		left_s8  <= left_s7;
		u2_s8    <= (fp5_s7 <<< 17) + (p4_w <<< 35);
		fp2sh_s8 <= fp2_s7 <<< 12;
		adp_s8   <= adp_s7;
		tc_s8    <= tc_s7;
		dis_s8   <= dis_s7;

		hv_s9    <= left_s8 * ((rmul_s8 + 32'sd8192) >>> 14);
		u2_s9    <= u2_s8;
		fp2sh_s9 <= fp2sh_s8;
		adp_s9   <= adp_s8;
		tc_s9    <= tc_s8;
		dis_s9   <= dis_s8;

		sqq_s10 <= (hv_s9 >>> 15) * (hv_s9 >>> 15);
		hv_s10  <= hv_s9;
		u_s10   <= u1_s9 + u2_s9;
		w0_s10  <= ensc_pkg::sdiv_p2(ffp3_s9, 8) + fp2sh_s9;
		pn_s10  <= 64'sd1048576 - {44'd0, adp_s9};
		tc_s10  <= tc_s9;
		dis_s10 <= dis_s9;

		m_s11    <= (sqq_s10 >>> 7) * h1_w;
		hv_s11   <= hv_s10;
		diff_s11 <= (pn_s10 <<< 31) - u_s10;
		tc_s11   <= tc_s10;
		dis_s11  <= dis_s10;

		hum_s12 <= hclamp_c[28:12];
		n_s12   <= diff_s11 * 64'sd3125;
		tc_s12  <= tc_s11;
		dis_s12 <= dis_s11;
	end

	// pressure products, 64-bit wrapping
	ensc_mul64 u_mul_ff   (.clk(clk), .en(1'b1), .a(f_s5),   .b(f_s5), .p(ff_s7));
	ensc_mul64 u_mul_fp5  (.clk(clk), .en(1'b1), .a(f_s5),   .b(p5_w), .p(fp5_s7));
	ensc_mul64 u_mul_fp2  (.clk(clk), .en(1'b1), .a(f_s5),   .b(p2_w), .p(fp2_s7));
	ensc_mul64 u_mul_u1   (.clk(clk), .en(1'b1), .a(ff_s7),  .b(p6_w), .p(u1_s9));
	ensc_mul64 u_mul_ffp3 (.clk(clk), .en(1'b1), .a(ff_s7),  .b(p3_w), .p(ffp3_s9));
	ensc_mul64 u_mul_w1   (.clk(clk), .en(1'b1), .a(wsum_c), .b(p1_w), .p(w1_s12));

	// classify: disabled measurement wins over a zero divisor
	always_comb begin
		out_valid    = vld_q[12];
		out_item.tc  = tc_s12;
		out_item.hum = hum_s12;
		out_item.num = n_s12;
		out_item.den = den_c;
		if (dis_s12) begin
			out_item.st = ensc_pkg::ST_DISABLED;
		end else if (den_c == '0) begin
			out_item.st = ensc_pkg::ST_DIV_ZERO;
		end else begin
			out_item.st = ensc_pkg::ST_OK;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/ensc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ensc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ensc_pkg::coef_t   coef,
	input  logic              q_empty,
	input  ensc_pkg::mid_t    q_data,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output ensc_pkg::result_t result
);

	localparam int DIV_W = 64;
	localparam int NST   = DIV_W + 10;
	localparam int LAST  = NST - 1;

	typedef struct packed {
		logic signed [31:0] tc;
		logic [16:0]        hum;
		logic [1:0]         st;
		logic               neg;
	} side_t;

	logic           en;
	logic           v_s1;
	logic [LAST:0]  v_q;
	ensc_pkg::mid_t mid_s1;
	side_t          sd_q [0:LAST];

	logic        [63:0] rem_q [0:DIV_W];
	logic        [63:0] dq_q  [0:DIV_W];
	logic        [63:0] den_q [0:DIV_W];
	logic        [64:0] trial_c [0:DIV_W-1];
	logic [DIV_W-1:0]   ge_c;

	logic               na_c, nb_c;
	logic        [63:0] mag_n_c, mag_d_c;
	logic signed [63:0] p7_w, p8_w, p9_w;
	logic signed [63:0] p_s3, p_s4, q_s4, p_s5, q_s5, p_s6, q_s6, pq_s6, p8p_s6;
	logic signed [63:0] p_s7, c2_s7, psum_s8, pqq_s8, s_s9, pf_s10;
	logic        [31:0] press_s11;

	assign en    = ~v_q[LAST] | pop;
	assign q_pop = en & ~q_empty;
	assign empty = ~v_q[LAST];

	assign p7_w = ensc_pkg::sx16_64(coef.p7);
	assign p8_w = ensc_pkg::sx16_64(coef.p8);
	assign p9_w = ensc_pkg::sx16_64(coef.p9);

	always_comb begin
		na_c    = mid_s1.num[63];
		nb_c    = mid_s1.den[63];
		mag_n_c = na_c ? (64'd0 - mid_s1.num) : mid_s1.num;
		mag_d_c = nb_c ? (64'd0 - mid_s1.den) : mid_s1.den;
		for (int k = 0; k < DIV_W; k++) begin
			trial_c[k] = {rem_q[k], dq_q[k][63]};
			ge_c[k]    = (trial_c[k] >= {1'b0, den_q[k]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_q  <= '0;
		end else if (en) begin
			v_s1 <= ~q_empty;
			v_q  <= {v_q[LAST-1:0], v_s1};
		end
	end

	// restoring divider on magnitudes, one quotient bit per stage, then sign, pressure correction and saturation
	always_ff @(posedge clk) begin
		if (en) begin
			mid_s1   <= q_data;
			sd_q[0]  <= '{tc: mid_s1.tc, hum: mid_s1.hum, st: mid_s1.st, neg: na_c ^ nb_c};
			rem_q[0] <= '0;
			dq_q[0]  <= mag_n_c;
			den_q[0] <= mag_d_c;
			for (int k = 0; k < DIV_W; k++) begin
				rem_q[k+1] <= ge_c[k] ? 64'(trial_c[k] - {1'b0, den_q[k]}) : trial_c[k][63:0];
				dq_q[k+1]  <= {dq_q[k][62:0], ge_c[k]};
				den_q[k+1] <= den_q[k];
			end
			for (int k = 1; k < NST; k++) begin
				sd_q[k] <= sd_q[k-1];
			end

			p_s3 <= sd_q[DIV_W].neg ? (64'd0 - dq_q[DIV_W]) : dq_q[DIV_W];

			p_s4 <= p_s3;
			q_s4 <= ensc_pkg::sdiv_p2(p_s3, 13);
			p_s5 <= p_s4;
			q_s5 <= q_s4;
			p_s6 <= p_s5;
			q_s6 <= q_s5;

			p_s7    <= p_s6;
			c2_s7   <= ensc_pkg::sdiv_p2(p8p_s6, 19);
			psum_s8 <= p_s7 + c2_s7;
			s_s9    <= ensc_pkg::sdiv_p2(pqq_s8, 25) + psum_s8;
			pf_s10  <= ensc_pkg::sdiv_p2(s_s9, 8) + (p7_w <<< 4);

			if (pf_s10[63]) begin
				press_s11 <= '0;
			end else if (|pf_s10[63:32]) begin
				press_s11 <= '1;
			end else begin
				press_s11 <= pf_s10[31:0];
			end
		end
	end

	ensc_mul64 u_mul_pq  (.clk(clk), .en(en), .a(p9_w),  .b(q_s4), .p(pq_s6));
	ensc_mul64 u_mul_p8p (.clk(clk), .en(en), .a(p8_w),  .b(p_s4), .p(p8p_s6));
	ensc_mul64 u_mul_pqq (.clk(clk), .en(en), .a(pq_s6), .b(q_s6), .p(pqq_s8));

	always_comb begin
		result.temp_centideg = sd_q[LAST].tc;
		result.humid_q22_10  = sd_q[LAST].hum;
		result.press_status  = sd_q[LAST].st;
		result.press_q24_8   = (sd_q[LAST].st == ensc_pkg::ST_OK) ? press_s11 : '0;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/env_sensor_compensation.sv =====
// Environmental sensor compensation.
// Input channel: sample carries raw temperature, pressure and humidity words;
// an item is taken on a rising edge with push high and full low.
// Result channel: while empty is low the oldest result sits on result; it is
// taken on a rising edge with pop high. Calibration lives in six coefficient
// registers on the APB port (64-bit data, register i at byte address 8*i);
// the user must write them only while no item is in flight, which the block
// itself does not enforce. Throughput: one item per cycle while full is low,
// set by the fully pipelined datapath. From accept to result an item passes
// through temperature, humidity and divisor/dividend work in the front pipeline,
// the middle queue, a register from the queue into the back, a register forming
// magnitudes, then 64 one-bit stages of the pressure divider and the pressure
// correction and saturation registers in the back pipeline.
// full rises when the front pipeline plus the middle queue hold QUEUE_DEPTH
// items. When the receiver stalls the back pipeline freezes in place, the
// front keeps running into the middle queue until it is full.
// Reset clears the coefficient registers, all valid state and the middle queue;
// empty is high and full is low right after reset.
`timescale 1ns / 1ps
`default_nettype none
module env_sensor_compensation #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [5:0]        paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	input  logic              push,
	output logic              full,
	input  ensc_pkg::sample_t sample,
	input  logic              pop,
	output logic              empty,
	output ensc_pkg::result_t result
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [47:0] temp_coeffs_q;
	logic [47:0] press_coeffs_a_q;
	logic [47:0] press_coeffs_b_q;
	logic [47:0] press_coeffs_c_q;
	logic [31:0] humid_coeffs_a_q;
	logic [39:0] humid_coeffs_b_q;

	ensc_pkg::coef_t coef;
	ensc_pkg::mid_t  front_item;
	ensc_pkg::mid_t  queue_item;
	logic            front_valid;
	logic            queue_empty;
	logic            queue_pop;
	logic            accept;
	logic            reg_wr;
	logic [2:0]      reg_idx;
	logic [CNT_W-1:0] cnt_q;

	assign pready  = 1'b1;
	assign reg_wr  = psel & penable & pwrite;
	assign reg_idx = paddr[5:3];
	assign accept  = push & ~full;
	assign full    = (cnt_q == CNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q    <= '0;
			press_coeffs_a_q <= '0;
			press_coeffs_b_q <= '0;
			press_coeffs_c_q <= '0;
			humid_coeffs_a_q <= '0;
			humid_coeffs_b_q <= '0;
		end else if (reg_wr) begin
			unique case (reg_idx)
				ensc_pkg::REG_TEMP:    temp_coeffs_q    <= pwdata[47:0];
				ensc_pkg::REG_PRESS_A: press_coeffs_a_q <= pwdata[47:0];
				ensc_pkg::REG_PRESS_B: press_coeffs_b_q <= pwdata[47:0];
				ensc_pkg::REG_PRESS_C: press_coeffs_c_q <= pwdata[47:0];
				ensc_pkg::REG_HUMID_A: humid_coeffs_a_q <= pwdata[31:0];
				ensc_pkg::REG_HUMID_B: humid_coeffs_b_q <= pwdata[39:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ensc_pkg::REG_TEMP:    prdata = {16'd0, temp_coeffs_q};
			ensc_pkg::REG_PRESS_A: prdata = {16'd0, press_coeffs_a_q};
			ensc_pkg::REG_PRESS_B: prdata = {16'd0, press_coeffs_b_q};
			ensc_pkg::REG_PRESS_C: prdata = {16'd0, press_coeffs_c_q};
			ensc_pkg::REG_HUMID_A: prdata = {32'd0, humid_coeffs_a_q};
			ensc_pkg::REG_HUMID_B: prdata = {24'd0, humid_coeffs_b_q};
			default:               prdata = '0;
		endcase
	end

	always_comb begin
		coef.t1 = temp_coeffs_q[47:32];
		coef.t2 = temp_coeffs_q[31:16];
		coef.t3 = temp_coeffs_q[15:0];
		coef.p1 = press_coeffs_a_q[47:32];
		coef.p2 = press_coeffs_a_q[31:16];
		coef.p3 = press_coeffs_a_q[15:0];
		coef.p4 = press_coeffs_b_q[47:32];
		coef.p5 = press_coeffs_b_q[31:16];
		coef.p6 = press_coeffs_b_q[15:0];
		coef.p7 = press_coeffs_c_q[47:32];
		coef.p8 = press_coeffs_c_q[31:16];
		coef.p9 = press_coeffs_c_q[15:0];
		coef.h1 = humid_coeffs_a_q[31:24];
		coef.h2 = humid_coeffs_a_q[23:8];
		coef.h3 = humid_coeffs_a_q[7:0];
		coef.h4 = humid_coeffs_b_q[39:24];
		coef.h5 = humid_coeffs_b_q[23:8];
		coef.h6 = humid_coeffs_b_q[7:0];
	end

	// credits: items in the front pipeline plus items parked in the middle queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			unique case ({accept, queue_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	ensc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.coef     (coef),
		.in_valid (accept),
		.sample   (sample),
		.out_valid(front_valid),
		.out_item (front_item)
	);

	ensc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (front_valid),
		.wdata (front_item),
		.rd_en (queue_pop),
		.rdata (queue_item),
		.empty (queue_empty)
	);

	ensc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.coef   (coef),
		.q_empty(queue_empty),
		.q_data (queue_item),
		.q_pop  (queue_pop),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/ensc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ensc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              pop,
	input logic              empty,
	input ensc_pkg::result_t result
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result channel not empty during reset");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.press_status == ensc_pkg::ST_OK ||
			result.press_status == ensc_pkg::ST_DISABLED ||
			result.press_status == ensc_pkg::ST_DIV_ZERO))
		else $error("undefined pressure status");

	a_press_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.press_status != ensc_pkg::ST_OK) |-> (result.press_q24_8 == '0))
		else $error("pressure not zero with bad status");

	a_humid_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.humid_q22_10 <= ensc_pkg::HUM_MAX))
		else $error("humidity above full scale");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("stalled result changed");

endmodule

bind env_sensor_compensation ensc_checker u_ensc_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.pop   (pop),
	.empty (empty),
	.result(result)
);
`default_nettype wire
